// ===== src/cma_pkg.sv =====
// Shared constants and types for the centered moving average block.
`default_nettype none

package cma_pkg;

    localparam int MAX_HALF_WIDTH_DEF = 31;
    localparam int SAMPLE_BITS_DEF    = 16;

    localparam int HALF_WIDTH_BITS = 5;
    localparam int INV_BITS        = 21;
    localparam int CFG_DATA_BITS   = 21;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int FRAC_BITS       = 20;
    localparam int SUM_GUARD_BITS  = 8;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_WIDTH = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INV_WINDOW = 1'b1;

    localparam logic [INV_BITS-1:0] INV_WINDOW_RESET = 21'h100000;

    // Per-cycle command to the history memory.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
        logic flush;
    } hist_ctl_t;

endpackage

`default_nettype wire

// ===== src/cma_history.sv =====
// Circular history memory with one write port and two registered read taps.
`default_nettype none

module cma_history #(
    parameter int MAX_HALF_WIDTH = cma_pkg::MAX_HALF_WIDTH_DEF,
    parameter int SAMPLE_BITS    = cma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire cma_pkg::hist_ctl_t                  ctl,
    input  wire logic [$clog2(MAX_HALF_WIDTH+1)-1:0] half,
    input  wire logic [$clog2(MAX_HALF_WIDTH+1)-1:0] flush_ofs,
    input  wire logic [SAMPLE_BITS-1:0]              wr_data,
    output logic      [SAMPLE_BITS-1:0]              rd_sub,
    output logic      [SAMPLE_BITS-1:0]              rd_tap
);

    localparam int DEPTH = 2 * MAX_HALF_WIDTH + 2;
    localparam int AW    = $clog2(DEPTH);

    logic [SAMPLE_BITS-1:0] mem [DEPTH];

    logic [AW-1:0]          wp_reg;
    logic [AW-1:0]          wp_next;
    logic [AW-1:0]          sub_ofs;
    logic [AW-1:0]          tap_ofs;
    logic [AW-1:0]          sub_addr;
    logic [AW-1:0]          tap_addr;
    logic [SAMPLE_BITS-1:0] rd_sub_reg;
    logic [SAMPLE_BITS-1:0] rd_tap_reg;

    // Step back from the newest entry, wrapping around the ring.
    function automatic logic [AW-1:0] back(input logic [AW-1:0] base,
                                           input logic [AW-1:0] ofs);
        logic [AW:0] diff;
        diff = {1'b0, base} - {1'b0, ofs};
        if (base < ofs)
        begin
            diff = diff + (AW+1)'(DEPTH);
        end
        return diff[AW-1:0];
    endfunction

    assign wp_next = (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1);

    // Leaving sample sits 2h back from the newest before this write.
    assign sub_ofs = AW'({half, 1'b0});

    always_comb
    begin
        if (ctl.flush)
        begin
            tap_ofs = AW'(flush_ofs);
        end
        else if (half == '0)
        begin
            tap_ofs = '0;
        end
        else
        begin
            tap_ofs = AW'(half) - AW'(1);
        end
    end

    assign sub_addr = back(wp_reg, sub_ofs);
    assign tap_addr = back(wp_reg, tap_ofs);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
        end
        else if (ctl.wr_en)
        begin
            wp_reg <= wp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wp_next] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_sub_reg <= mem[sub_addr];
            rd_tap_reg <= mem[tap_addr];
        end
    end

    assign rd_sub = rd_sub_reg;
    assign rd_tap = rd_tap_reg;

endmodule

`default_nettype wire

// ===== src/centered_moving_average.sv =====
// Centered moving average: boxcar of width 2h+1 over one waveform, output h beats behind.
// Each result beat is registered through stages 1-3 and the output register.
// Throughput: one input beat per cycle unless the output stalls; after an end-of-wave
// beat the input stalls while the held-back samples drain raw from the history memory.
// Reset: asynchronous, active low; clears counters, window sum, pipeline valids and
// config (half_width = 0, inv_window = 2^20). History memory is not cleared.
`default_nettype none

module centered_moving_average #(
    parameter int MAX_HALF_WIDTH = cma_pkg::MAX_HALF_WIDTH_DEF,
    parameter int SAMPLE_BITS    = cma_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // configuration write port
    input  wire logic                                 cfg_we,
    input  wire logic [cma_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  wire logic [cma_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    // input channel
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]        sample,
    input  wire logic                                 end_of_wave,
    // output channel
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic signed [SAMPLE_BITS-1:0]             value,
    output logic                                      averaged,
    output logic                                      last_out
);

    localparam int HW        = $clog2(MAX_HALF_WIDTH + 1);
    localparam int COUNT_SAT = 4 * MAX_HALF_WIDTH + 3;
    localparam int CW        = $clog2(COUNT_SAT + 1);
    localparam int SUM_BITS  = SAMPLE_BITS + cma_pkg::SUM_GUARD_BITS;
    localparam int PROD_BITS = SUM_BITS + cma_pkg::INV_BITS + 1;
    localparam int Q_BITS    = PROD_BITS - cma_pkg::FRAC_BITS;
    localparam longint SMAX  = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam logic signed [Q_BITS-1:0] Q_HI = Q_BITS'(SMAX);
    localparam logic signed [Q_BITS-1:0] Q_LO = Q_BITS'(-SMAX - 1);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [cma_pkg::HALF_WIDTH_BITS-1:0] half_width_reg;
    logic [cma_pkg::INV_BITS-1:0]        inv_window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_width_reg <= '0;
            inv_window_reg <= cma_pkg::INV_WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cma_pkg::CFG_HALF_WIDTH:
                begin
                    half_width_reg <= cfg_data[cma_pkg::HALF_WIDTH_BITS-1:0];
                end
                cma_pkg::CFG_INV_WINDOW:
                begin
                    inv_window_reg <= cfg_data[cma_pkg::INV_BITS-1:0];
                end
            endcase
        end
    end

    // Effective half width, clamped to what the history can hold.
    logic [7:0]    hw_ext;
    logic [HW-1:0] h;
    logic [CW-1:0] h_c;
    logic [CW-1:0] two_h;
    logic [CW-1:0] two_h1;

    assign hw_ext = 8'(half_width_reg);
    assign h      = (hw_ext > 8'(MAX_HALF_WIDTH)) ? HW'(MAX_HALF_WIDTH) : HW'(hw_ext);
    assign h_c    = CW'(h);
    assign two_h  = CW'({h, 1'b0});
    assign two_h1 = two_h + CW'(1);

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage loads when the one after it has room
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic out_valid_reg;

    logic ok0;
    logic ok1;
    logic ok2;
    logic ok3;

    assign ok3 = !out_valid_reg || !out_stall;
    assign ok2 = !s3_valid_reg || ok3;
    assign ok1 = !s2_valid_reg || ok2;
    assign ok0 = !s1_valid_reg || ok1;

    // ------------------------------------------------------------------
    // Stage 0: accept beats, count samples, sequence the end-of-wave drain
    // ------------------------------------------------------------------
    logic          flushing_reg;
    logic [HW-1:0] fl_cnt_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_inc;
    logic [HW-1:0] pending;
    logic          in_accept;
    logic          flush_issue;
    logic          s1_load;

    assign in_stall    = flushing_reg || !ok0;
    assign in_accept   = in_valid && !in_stall;
    assign flush_issue = flushing_reg && ok0;
    assign s1_load     = in_accept || flush_issue;

    assign count_inc = (count_reg == CW'(COUNT_SAT)) ? count_reg : count_reg + CW'(1);

    // Samples still held back when the wave ends: h, or all of a short wave.
    assign pending = (count_reg >= h_c) ? h : HW'(count_reg + CW'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            flushing_reg <= 1'b0;
            fl_cnt_reg   <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                count_reg <= end_of_wave ? '0 : count_inc;
                if (end_of_wave && pending != '0)
                begin
                    flushing_reg <= 1'b1;
                    fl_cnt_reg   <= pending;
                end
            end
            else if (flush_issue)
            begin
                // Drain oldest first; stop after the newest entry.
                fl_cnt_reg <= fl_cnt_reg - HW'(1);
                if (fl_cnt_reg == HW'(1))
                begin
                    flushing_reg <= 1'b0;
                end
            end
        end
    end

    // History memory: write the new sample, read the leaving sample and the
    // sample now h beats old (or the drain entry) in the same cycle.
    cma_pkg::hist_ctl_t     hist_ctl;
    logic [SAMPLE_BITS-1:0] rd_sub;
    logic [SAMPLE_BITS-1:0] rd_tap;

    assign hist_ctl.wr_en = in_accept;
    assign hist_ctl.rd_en = s1_load;
    assign hist_ctl.flush = flushing_reg;

    cma_history #(
        .MAX_HALF_WIDTH (MAX_HALF_WIDTH),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_history (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (hist_ctl),
        .half      (h),
        .flush_ofs (fl_cnt_reg - HW'(1)),
        .wr_data   (sample),
        .rd_sub    (rd_sub),
        .rd_tap    (rd_tap)
    );

    // ------------------------------------------------------------------
    // Stage 1: operation register, read data arrives alongside
    // ------------------------------------------------------------------
    logic                          s1_flush_reg;
    logic                          s1_last_reg;
    logic signed [SAMPLE_BITS-1:0] s1_x_reg;
    logic [CW-1:0]                 s1_n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (ok0)
        begin
            s1_valid_reg <= s1_load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ok0 && s1_load)
        begin
            s1_flush_reg <= flushing_reg;
            s1_last_reg  <= flushing_reg ? (fl_cnt_reg == HW'(1)) : end_of_wave;
            s1_x_reg     <= sample;
            s1_n_reg     <= count_reg;
        end
    end

    // Running window sum: add the newcomer, drop the sample leaving the window.
    logic signed [SUM_BITS-1:0] window_sum_reg;
    logic signed [SUM_BITS-1:0] sub_term;
    logic signed [SUM_BITS-1:0] sum_next;
    logic                       s1_emit;
    logic                       s1_avg;
    logic                       s1_last_out;
    logic                       sum_step;

    assign sub_term = (s1_n_reg >= two_h1) ? SUM_BITS'($signed(rd_sub)) : '0;
    assign sum_next = window_sum_reg + SUM_BITS'(s1_x_reg) - sub_term;

    // A sample beat releases a result once h samples precede it in the wave.
    assign s1_emit     = s1_flush_reg || (s1_n_reg >= h_c);
    assign s1_avg      = !s1_flush_reg && (s1_n_reg >= two_h);
    assign s1_last_out = s1_flush_reg ? s1_last_reg : (s1_last_reg && h == '0);
    assign sum_step    = ok1 && s1_valid_reg && !s1_flush_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_sum_reg <= '0;
        end
        else if (sum_step)
        begin
            window_sum_reg <= s1_last_reg ? '0 : sum_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: result candidate with its window sum
    // ------------------------------------------------------------------
    logic signed [SUM_BITS-1:0]    s2_sum_reg;
    logic signed [SAMPLE_BITS-1:0] s2_raw_reg;
    logic                          s2_avg_reg;
    logic                          s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (ok1)
        begin
            s2_valid_reg <= s1_valid_reg && s1_emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ok1)
        begin
            s2_sum_reg  <= sum_next;
            s2_raw_reg  <= rd_tap;
            s2_avg_reg  <= s1_avg;
            s2_last_reg <= s1_last_out;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: scale the sum by the reciprocal window width
    // ------------------------------------------------------------------
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [PROD_BITS-1:0]   s3_prod_reg;
    logic signed [SAMPLE_BITS-1:0] s3_raw_reg;
    logic                          s3_avg_reg;
    logic                          s3_last_reg;

    assign prod_next = PROD_BITS'(s2_sum_reg) * PROD_BITS'($signed({1'b0, inv_window_reg}));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (ok2)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ok2)
        begin
            s3_prod_reg <= prod_next;
            s3_raw_reg  <= s2_raw_reg;
            s3_avg_reg  <= s2_avg_reg;
            s3_last_reg <= s2_last_reg;
        end
    end

    // Floor by dropping fraction bits (arithmetic), then clamp to sample range.
    logic signed [Q_BITS-1:0]      quot;
    logic signed [SAMPLE_BITS-1:0] mean;

    assign quot = s3_prod_reg[PROD_BITS-1:cma_pkg::FRAC_BITS];

    always_comb
    begin
        priority if (quot > Q_HI)
        begin
            mean = SAMPLE_BITS'(SMAX);
        end
        else if (quot < Q_LO)
        begin
            mean = SAMPLE_BITS'(-SMAX - 1);
        end
        else
        begin
            mean = quot[SAMPLE_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Output register: holds the beat while the consumer stalls
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] value_reg;
    logic                          averaged_reg;
    logic                          last_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ok3)
        begin
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ok3)
        begin
            value_reg    <= s3_avg_reg ? mean : s3_raw_reg;
            averaged_reg <= s3_avg_reg;
            last_out_reg <= s3_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign averaged  = averaged_reg;
    assign last_out  = last_out_reg;

`ifndef SYNTHESIS
    // The window sum is empty once the end-of-wave sample has updated it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sum_step && s1_last_reg) |=> (window_sum_reg == '0))
    else $error("window sum not cleared after end of wave");

    // The sample count restarts after an end-of-wave beat is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && end_of_wave) |=> (count_reg == '0))
    else $error("sample count not cleared after end of wave");

    // A drain never runs past the held-back samples.
    assert property (@(posedge clk) disable iff (!rst_n)
        flushing_reg |-> (fl_cnt_reg != '0 && fl_cnt_reg <= h))
    else $error("drain counter out of range");
`endif

endmodule

`default_nettype wire
